@@ hw/rtl/hnsu_pkg.sv @@
// Package for the heightmap neighbour smoothing unit.
// Holds widths, codes and control structs shared by the interfaces and modules.
// No dependencies.
`default_nettype none

package hnsu_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 1024;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;

  localparam int unsigned GRID_WIDTH_BITS  = 11;
  localparam int unsigned GRID_HEIGHT_BITS = 16;
  localparam int unsigned ROW_BITS         = GRID_HEIGHT_BITS + 1;

  localparam int unsigned CFG_IDX_BITS     = 2;
  localparam int unsigned CFG_DATA_BITS    = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RST  = 11'd1024;
  localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RST = 16'd1024;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  // neighbour selection for the window datapath
  typedef struct packed {
    logic edge_emit;   // right-edge result of the row before last
    logic width_one;   // grid is one sample wide
    logic col_one;     // current sample sits in column 1
  } win_sel_t;

  // per-word control carried from the input register to the result stage
  typedef struct packed {
    logic edge_emit;
    logic frame_done;  // edge result closes the grid, no window update
    logic norm_emit;
    logic width_one;
    logic col_one;
    logic row_zero;
    logic row_ge2;
    logic row_in_grid;
  } s1_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/hnsu_in_if.sv @@
// Input channel of the heightmap neighbour smoothing unit: valid/ready plus request word.
// Depends on hnsu_pkg.
`default_nettype none

interface hnsu_in_if
  import hnsu_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SAMPLE_BITS-1:0] height;

  modport source (output valid, output req_type, output height, input ready);
  modport sink   (input valid, input req_type, input height, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hnsu_out_if.sv @@
// Result channel of the heightmap neighbour smoothing unit: valid/ready plus result word.
// Depends on hnsu_pkg.
`default_nettype none

interface hnsu_out_if
  import hnsu_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] smoothed;
  logic                   row_end;
  logic                   frame_end;

  modport source (output valid, output smoothed, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input smoothed, input row_end, input frame_end,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hnsu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hnsu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/hnsu_window.sv @@
// Neighbour window of the smoothing unit: last two columns and the eight-neighbour mean.
// Depends on hnsu_pkg.
`default_nettype none

module hnsu_window
  import hnsu_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  win_sel_t               sel_i,
  input  logic [SAMPLE_BITS-1:0] top_i,
  input  logic [SAMPLE_BITS-1:0] mid_i,
  input  logic [SAMPLE_BITS-1:0] bot_i,
  output logic [SAMPLE_BITS-1:0] smoothed_o
);

  localparam int unsigned SW = SAMPLE_BITS + 3;

  // column 1 is the older of the two kept columns
  logic [SAMPLE_BITS-1:0] c1_top_q, c1_mid_q, c1_bot_q;
  logic [SAMPLE_BITS-1:0] c2_top_q, c2_mid_q, c2_bot_q;

  logic [SAMPLE_BITS-1:0] l_top, l_mid, l_bot;
  logic [SAMPLE_BITS-1:0] r_top, r_mid, r_bot;
  logic [SW-1:0]          sum;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      c1_top_q <= c2_top_q;
      c1_mid_q <= c2_mid_q;
      c1_bot_q <= c2_bot_q;
      c2_top_q <= top_i;
      c2_mid_q <= mid_i;
      c2_bot_q <= bot_i;
    end
  end

  always_comb begin
    if (sel_i.edge_emit ? sel_i.width_one : sel_i.col_one) begin
      l_top = c2_top_q;
      l_mid = c2_mid_q;
      l_bot = c2_bot_q;
    end else begin
      l_top = c1_top_q;
      l_mid = c1_mid_q;
      l_bot = c1_bot_q;
    end
    if (sel_i.edge_emit) begin
      r_top = c2_top_q;
      r_mid = c2_mid_q;
      r_bot = c2_bot_q;
    end else begin
      r_top = top_i;
      r_mid = mid_i;
      r_bot = bot_i;
    end
    sum = SW'(l_top) + SW'(l_mid) + SW'(l_bot)
        + SW'(c2_top_q) + SW'(c2_bot_q)
        + SW'(r_top) + SW'(r_mid) + SW'(r_bot);
  end

  assign smoothed_o = sum[SW-1:3];

endmodule

`default_nettype wire

@@ hw/rtl/heightmap_neighbour_smoothing_unit.sv @@
// Heightmap neighbour smoothing unit: 3x3 mean without centre, clamped to the grid edge.
// Depends on hnsu_pkg, hnsu_in_if, hnsu_out_if, hnsu_ram and hnsu_window.
//
// Usage: height samples enter on req_i in raster order, grid_width per row and
// grid_height rows, set through the cfg write port (index 0 width, 1 height;
// a write to either restarts the frame). Each result word on res_o is the mean of the
// eight neighbours of one sample, in raster order. Results trail the input by
// one row and one sample, so the grid is flushed with grid_width + 1 drain
// words after its last sample; the word with frame_end closes the grid.
// Throughput: one word per cycle while res_o takes results. A word is taken into
// an input register, where the two line buffer RAMs are read; from there the
// result is computed into the output register, which drives res_o.
// Reset: counters restart, registers return to 1024 x 1024. Line buffers are
// not cleared; each entry is written in a frame before it is read.
// Stall: the output register holds its word while res_o.ready is low; one
// more word may wait in the input register, then req_i.ready drops.
`default_nettype none

module heightmap_neighbour_smoothing_unit
  import hnsu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  hnsu_in_if.sink                  req_i,
  hnsu_out_if.source               res_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [GRID_WIDTH_BITS-1:0]  grid_width_q;
  logic [GRID_HEIGHT_BITS-1:0] grid_height_q;
  logic [AW-1:0]               in_column_q;
  logic [ROW_BITS-1:0]         in_row_q;

  logic [WW-1:0]               w_eff;
  logic [GRID_HEIGHT_BITS-1:0] h_eff;

  logic                        drain, row_in_grid, ignore, col_zero, last_col;
  logic                        accept, load;
  s1_ctrl_t                    ctrl_d;

  logic                        s1_valid_q;
  s1_ctrl_t                    s1_ctrl_q;
  logic [SAMPLE_BITS-1:0]      s1_sample_q;
  logic [AW-1:0]               s1_addr_q;
  logic                        fwd_hit_q;
  logic [SAMPLE_BITS-1:0]      fwd_above_q, fwd_cur_q;

  logic                        s1_emit, s1_go, s1_write, out_free;
  logic [SAMPLE_BITS-1:0]      above_rd, cur_rd, above_use, cur_use;
  logic [SAMPLE_BITS-1:0]      top, mid, bot;
  logic [SAMPLE_BITS-1:0]      smoothed;
  win_sel_t                    win_sel;

  logic                        out_valid_q;
  logic [SAMPLE_BITS-1:0]      out_smoothed_q;
  logic                        out_row_end_q, out_frame_end_q;

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(grid_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width_q);
    end
    h_eff = (grid_height_q == '0) ? GRID_HEIGHT_BITS'(1) : grid_height_q;
  end

  // input stage decode
  always_comb begin
    drain       = (req_i.req_type == REQ_DRAIN);
    row_in_grid = in_row_q < {1'b0, h_eff};
    ignore      = drain && row_in_grid;
    col_zero    = (in_column_q == '0);
    last_col    = (WW'(in_column_q) + WW'(1)) == w_eff;

    ctrl_d.edge_emit   = col_zero && (in_row_q >= ROW_BITS'(2));
    ctrl_d.frame_done  = in_row_q > {1'b0, h_eff};
    ctrl_d.norm_emit   = !col_zero && (in_row_q != '0);
    ctrl_d.width_one   = (w_eff == WW'(1));
    ctrl_d.col_one     = (in_column_q == AW'(1));
    ctrl_d.row_zero    = (in_row_q == '0);
    ctrl_d.row_ge2     = (in_row_q >= ROW_BITS'(2));
    ctrl_d.row_in_grid = row_in_grid;
  end

  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_emit     = s1_ctrl_q.edge_emit || s1_ctrl_q.norm_emit;
  assign s1_go       = s1_valid_q && (!s1_emit || out_free);
  assign s1_write    = s1_go && !(s1_ctrl_q.edge_emit && s1_ctrl_q.frame_done);
  assign req_i.ready = !s1_valid_q || s1_go;
  assign accept      = req_i.valid && req_i.ready;
  assign load        = accept && !ignore;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      in_column_q   <= '0;
      in_row_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH: begin
          grid_width_q <= cfg_data_i[GRID_WIDTH_BITS-1:0];
          in_column_q  <= '0;
          in_row_q     <= '0;
        end
        CFG_GRID_HEIGHT: begin
          grid_height_q <= cfg_data_i[GRID_HEIGHT_BITS-1:0];
          in_column_q   <= '0;
          in_row_q      <= '0;
        end
        default: ;
      endcase
    end else if (load) begin
      if (ctrl_d.edge_emit && ctrl_d.frame_done) begin
        in_column_q <= '0;
        in_row_q    <= '0;
      end else if (last_col) begin
        in_column_q <= '0;
        in_row_q    <= in_row_q + ROW_BITS'(1);
      end else begin
        in_column_q <= in_column_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // payload of the input register; forward a write that lands on the read address
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_ctrl_q   <= ctrl_d;
      s1_sample_q <= req_i.height;
      s1_addr_q   <= in_column_q;
      fwd_hit_q   <= s1_write && (s1_addr_q == in_column_q);
      fwd_above_q <= mid;
      fwd_cur_q   <= bot;
    end
  end

  hnsu_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_addr_q),
    .wdata_i (mid),
    .re_i    (load),
    .raddr_i (in_column_q),
    .rdata_o (above_rd)
  );

  hnsu_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_current (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_addr_q),
    .wdata_i (bot),
    .re_i    (load),
    .raddr_i (in_column_q),
    .rdata_o (cur_rd)
  );

  // column triple, clamped vertically around the middle row
  always_comb begin
    above_use = fwd_hit_q ? fwd_above_q : above_rd;
    cur_use   = fwd_hit_q ? fwd_cur_q : cur_rd;
    if (s1_ctrl_q.row_zero) begin
      mid = s1_sample_q;
      top = s1_sample_q;
    end else begin
      mid = cur_use;
      top = s1_ctrl_q.row_ge2 ? above_use : cur_use;
    end
    bot = s1_ctrl_q.row_in_grid ? s1_sample_q : mid;

    win_sel.edge_emit = s1_ctrl_q.edge_emit;
    win_sel.width_one = s1_ctrl_q.width_one;
    win_sel.col_one   = s1_ctrl_q.col_one;
  end

  hnsu_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .shift_i    (s1_write),
    .sel_i      (win_sel),
    .top_i      (top),
    .mid_i      (mid),
    .bot_i      (bot),
    .smoothed_o (smoothed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit) begin
      out_smoothed_q  <= smoothed;
      out_row_end_q   <= s1_ctrl_q.edge_emit;
      out_frame_end_q <= s1_ctrl_q.edge_emit && s1_ctrl_q.frame_done;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.smoothed  = out_smoothed_q;
  assign res_o.row_end   = out_row_end_q;
  assign res_o.frame_end = out_frame_end_q;

endmodule

`default_nettype wire
